[sv/uraf_pkg.sv]
// ----------------------------------------------------------------------------
// uraf_pkg
// Shared sizes, codes and types of the register access frame slave.
// ----------------------------------------------------------------------------
`default_nettype none

package uraf_pkg;

    localparam int NUM_REGS    = 9;
    localparam int MAX_BYTES   = 32;
    localparam int STORE_DEPTH = NUM_REGS * MAX_BYTES;

    localparam int REG_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int CNT_W  = $clog2(MAX_BYTES + 1);
    localparam int STG_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEADER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OK_CODE      = CFG_IDX_W'(1);

    // device id held in byte 0 of register 0
    localparam logic [7:0] ID_RESET = 8'h80;

    typedef logic [1:0] t_emit_sel;
    localparam t_emit_sel EM_HDR  = 2'd0;
    localparam t_emit_sel EM_OK   = 2'd1;
    localparam t_emit_sel EM_DATA = 2'd2;
    localparam t_emit_sel EM_SUM  = 2'd3;

    typedef struct packed {
        logic      sum_init;
        logic      sum_add;
        logic      reg_load;
        logic      len_load;
        logic      stage_wr;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      commit_rd;
        logic      fetch;
        logic      emit;
        t_emit_sel emit_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic hdr_match;
        logic id_match;
        logic reg_ok;
        logic len_ok;
        logic is_write;
        logic data_last;
        logic cnt_done;
        logic sum_match;
        logic out_free;
    } t_dp_sts;

    typedef struct packed {
        logic       hit;
        logic [1:0] slot;
    } t_persist;

    // registers that are mirrored to non-volatile storage
    function automatic t_persist persist_lookup(input logic [6:0] reg_idx);
        t_persist p;
        p.hit  = 1'b1;
        p.slot = 2'd0;
        unique case (reg_idx)
            7'd0:    p.slot = 2'd0;
            7'd2:    p.slot = 2'd1;
            7'd3:    p.slot = 2'd2;
            7'd8:    p.slot = 2'd3;
            default: p.hit  = 1'b0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[sv/uraf_ctrl.sv]
// ----------------------------------------------------------------------------
// uraf_ctrl
// Frame parser and response sequencer; drives the datapath by commands.
// ----------------------------------------------------------------------------
`default_nettype none

module uraf_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_rx_valid,
    output logic             o_rx_ready,
    input  uraf_pkg::t_dp_sts i_sts,
    output uraf_pkg::t_dp_cmd o_cmd
);
    import uraf_pkg::*;

    localparam logic [3:0] ST_HDR       = 4'd0;
    localparam logic [3:0] ST_ID        = 4'd1;
    localparam logic [3:0] ST_REG       = 4'd2;
    localparam logic [3:0] ST_LEN       = 4'd3;
    localparam logic [3:0] ST_DATA      = 4'd4;
    localparam logic [3:0] ST_WSUM      = 4'd5;
    localparam logic [3:0] ST_RSUM      = 4'd6;
    localparam logic [3:0] ST_COMMIT    = 4'd7;
    localparam logic [3:0] ST_SEND_HDR  = 4'd8;
    localparam logic [3:0] ST_SEND_OK   = 4'd9;
    localparam logic [3:0] ST_FETCH     = 4'd10;
    localparam logic [3:0] ST_SEND_DATA = 4'd11;
    localparam logic [3:0] ST_SEND_SUM  = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       rx_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HDR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_rx_ready = (r_state == ST_HDR) || (r_state == ST_ID) || (r_state == ST_REG) ||
                        (r_state == ST_LEN) || (r_state == ST_DATA) ||
                        (r_state == ST_WSUM) || (r_state == ST_RSUM);
    assign rx_fire = i_rx_valid && o_rx_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_HDR: begin
                if (rx_fire) begin
                    o_cmd.sum_init = 1'b1;
                    n_state = i_sts.hdr_match ? ST_ID : ST_HDR;
                end
            end
            ST_ID: begin
                if (rx_fire) begin
                    o_cmd.sum_add = 1'b1;
                    n_state = i_sts.id_match ? ST_REG : ST_HDR;
                end
            end
            ST_REG: begin
                if (rx_fire) begin
                    o_cmd.sum_add  = 1'b1;
                    o_cmd.reg_load = 1'b1;
                    n_state = i_sts.reg_ok ? ST_LEN : ST_HDR;
                end
            end
            ST_LEN: begin
                if (rx_fire) begin
                    o_cmd.sum_add  = 1'b1;
                    o_cmd.len_load = 1'b1;
                    o_cmd.cnt_clr  = 1'b1;
                    if (!i_sts.len_ok) begin
                        n_state = ST_HDR;
                    end else begin
                        n_state = i_sts.is_write ? ST_DATA : ST_RSUM;
                    end
                end
            end
            ST_DATA: begin
                if (rx_fire) begin
                    o_cmd.sum_add  = 1'b1;
                    o_cmd.stage_wr = 1'b1;
                    o_cmd.cnt_inc  = 1'b1;
                    n_state = i_sts.data_last ? ST_WSUM : ST_DATA;
                end
            end
            ST_WSUM: begin
                if (rx_fire) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = i_sts.sum_match ? ST_COMMIT : ST_HDR;
                end
            end
            ST_RSUM: begin
                if (rx_fire) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = i_sts.sum_match ? ST_SEND_HDR : ST_HDR;
                end
            end
            ST_COMMIT: begin
                // one staged byte per cycle; the store write follows in the next cycle
                if (!i_sts.cnt_done) begin
                    o_cmd.commit_rd = 1'b1;
                    o_cmd.cnt_inc   = 1'b1;
                end else begin
                    n_state = ST_SEND_HDR;
                end
            end
            ST_SEND_HDR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_HDR;
                    n_state = ST_SEND_OK;
                end
            end
            ST_SEND_OK: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_OK;
                    n_state = i_sts.is_write ? ST_SEND_SUM : ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state = ST_SEND_DATA;
            end
            ST_SEND_DATA: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_DATA;
                    o_cmd.cnt_inc  = 1'b1;
                    n_state = i_sts.data_last ? ST_SEND_SUM : ST_FETCH;
                end
            end
            ST_SEND_SUM: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = EM_SUM;
                    n_state = ST_HDR;
                end
            end
            default: begin
                n_state = ST_HDR;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/uraf_dp.sv]
// ----------------------------------------------------------------------------
// uraf_dp
// Checksum, frame fields, staging buffer, register store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module uraf_dp (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  uraf_pkg::t_dp_cmd                 i_cmd,
    output uraf_pkg::t_dp_sts                 o_sts,
    input  wire  [7:0]                        i_rx_byte,
    input  wire                               i_cfg_valid,
    input  wire  [uraf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [7:0]                        i_cfg_data,
    input  wire                               i_tx_ready,
    output logic                              o_tx_valid,
    output logic [7:0]                        o_tx_byte,
    output logic                              o_last_byte,
    output logic                              o_persist_request,
    output logic [1:0]                        o_persist_slot
);
    import uraf_pkg::*;

    logic [7:0]       r_frame_header;
    logic [7:0]       r_ok_code;
    logic [7:0]       r_dev_id;
    logic [7:0]       r_sum;
    logic [REG_W-1:0] r_tr;
    logic             r_is_write;
    logic [CNT_W-1:0] r_len;
    logic [CNT_W-1:0] r_cnt;

    logic [7:0]       r_stg [MAX_BYTES];
    logic [7:0]       r_store [STORE_DEPTH];
    // bytes of each register written since reset; entries above read as reset value
    logic [CNT_W-1:0] r_fill [NUM_REGS];

    logic             r_wr_pend;
    logic [STG_W-1:0] r_wr_idx;
    logic [7:0]       r_stg_q;
    logic [7:0]       r_st_q;
    logic             r_st_fill;
    logic             r_st_id0;

    logic             r_tx_valid;
    logic [7:0]       r_tx_byte;
    logic             r_last;
    logic             r_preq;
    logic [1:0]       r_pslot;

    logic [7:0]       data_byte;
    logic [7:0]       emit_byte;
    logic [CNT_W-1:0] wr_top;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] row_base;
    t_persist         pers;

    assign row_base = ADDR_W'(ADDR_W'(r_tr) * ADDR_W'(MAX_BYTES));
    assign wr_addr  = row_base + ADDR_W'(r_wr_idx);
    assign rd_addr  = row_base + ADDR_W'(r_cnt[STG_W-1:0]);
    assign wr_top   = CNT_W'(r_wr_idx) + CNT_W'(1);
    assign pers     = persist_lookup(7'(r_tr));

    assign data_byte = r_st_fill ? r_st_q : (r_st_id0 ? ID_RESET : 8'd0);

    always_comb begin
        unique case (i_cmd.emit_sel)
            EM_HDR:  emit_byte = r_frame_header;
            EM_OK:   emit_byte = r_ok_code;
            EM_DATA: emit_byte = data_byte;
            EM_SUM:  emit_byte = r_sum;
        endcase
    end

    always_comb begin
        o_sts.hdr_match = (i_rx_byte == r_frame_header);
        o_sts.id_match  = (i_rx_byte == r_dev_id);
        o_sts.reg_ok    = ({1'b0, i_rx_byte[6:0]} < 8'(NUM_REGS));
        o_sts.len_ok    = (i_rx_byte != 8'd0) && (i_rx_byte <= 8'(MAX_BYTES));
        o_sts.is_write  = r_is_write;
        o_sts.data_last = ((r_cnt + CNT_W'(1)) == r_len);
        o_sts.cnt_done  = (r_cnt == r_len);
        o_sts.sum_match = (i_rx_byte == r_sum);
        o_sts.out_free  = !r_tx_valid || i_tx_ready;
    end

    // control and field registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_header <= 8'd0;
            r_ok_code      <= 8'd0;
            r_dev_id       <= ID_RESET;
            r_sum          <= 8'd0;
            r_tr           <= '0;
            r_is_write     <= 1'b0;
            r_len          <= '0;
            r_cnt          <= '0;
            r_wr_pend      <= 1'b0;
            r_tx_valid     <= 1'b0;
            for (int k = 0; k < NUM_REGS; k++) begin
                r_fill[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_FRAME_HEADER) begin
                    r_frame_header <= i_cfg_data;
                end else if (i_cfg_index == CFG_OK_CODE) begin
                    r_ok_code <= i_cfg_data;
                end
            end

            if (i_cmd.sum_init) begin
                r_sum <= i_rx_byte;
            end else if (i_cmd.sum_add) begin
                r_sum <= r_sum + i_rx_byte;
            end else if (i_cmd.emit && (i_cmd.emit_sel == EM_DATA)) begin
                r_sum <= r_sum + data_byte;
            end

            if (i_cmd.reg_load) begin
                r_tr       <= REG_W'(i_rx_byte[6:0]);
                r_is_write <= i_rx_byte[7];
            end
            if (i_cmd.len_load) begin
                r_len <= CNT_W'(i_rx_byte);
            end

            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            r_wr_pend <= i_cmd.commit_rd;
            if (i_cmd.commit_rd) begin
                r_wr_idx <= r_cnt[STG_W-1:0];
            end
            if (r_wr_pend) begin
                if (wr_top > r_fill[r_tr]) begin
                    r_fill[r_tr] <= wr_top;
                end
                if ((r_tr == '0) && (r_wr_idx == '0)) begin
                    r_dev_id <= r_stg_q;
                end
            end

            if (i_cmd.emit) begin
                r_tx_valid <= 1'b1;
            end else if (i_tx_ready) begin
                r_tx_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_tx_byte <= emit_byte;
            r_last    <= (i_cmd.emit_sel == EM_SUM);
            r_preq    <= (i_cmd.emit_sel == EM_SUM) && r_is_write && pers.hit;
            r_pslot   <= ((i_cmd.emit_sel == EM_SUM) && r_is_write && pers.hit) ?
                         pers.slot : 2'd0;
        end
    end

    // staging buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.stage_wr) begin
            r_stg[r_cnt[STG_W-1:0]] <= i_rx_byte;
        end
        if (i_cmd.commit_rd) begin
            r_stg_q <= r_stg[r_cnt[STG_W-1:0]];
        end
    end

    // register store
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            r_store[wr_addr] <= r_stg_q;
        end
        if (i_cmd.fetch) begin
            r_st_q    <= r_store[rd_addr];
            r_st_fill <= (r_cnt < r_fill[r_tr]);
            r_st_id0  <= (r_tr == '0) && (r_cnt == '0);
        end
    end

    assign o_tx_valid        = r_tx_valid;
    assign o_tx_byte         = r_tx_byte;
    assign o_last_byte       = r_last;
    assign o_persist_request = r_preq;
    assign o_persist_slot    = r_pslot;

endmodule

`default_nettype wire

[sv/uart_register_access_frame_slave_core.sv]
// ----------------------------------------------------------------------------
// uart_register_access_frame_slave_core
// Register access frame slave fed by received serial bytes.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (i_rx_valid/o_rx_ready, i_rx_byte): one received byte per item.
//   tx channel (o_tx_valid/i_tx_ready): response bytes, o_last_byte on the final
//   one, o_persist_request/o_persist_slot on it if a mirrored register is written.
//   cfg channel (i_cfg_valid/o_cfg_ready): index 0 frame header, 1 ok code;
//   always ready, write only while no frame is in flight.
// Timing:
//   Request bytes are taken one per cycle while rx is ready. The checksum byte
//   of a write then copies the staged data into the store at one byte per
//   cycle before 3 answer bytes go out; a read emits header and ok code, then
//   for each data byte a store read and then its output, then the checksum.
//   rx is held off until the answer's last byte is loaded into the output
//   register. A stalled receiver holds the output register and the sequence
//   waits.
// Reset:
//   Parser returns to idle, config registers to 0, device id to 128; the store
//   keeps a per-register fill count, so no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_register_access_frame_slave_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_rx_valid,
    output logic                           o_rx_ready,
    input  wire  [7:0]                     i_rx_byte,
    output logic                           o_tx_valid,
    input  wire                            i_tx_ready,
    output logic [7:0]                     o_tx_byte,
    output logic                           o_last_byte,
    output logic                           o_persist_request,
    output logic [1:0]                     o_persist_slot,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire  [uraf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [7:0]                     i_cfg_data
);
    import uraf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    uraf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx_valid (i_rx_valid),
        .o_rx_ready (o_rx_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    uraf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_rx_byte         (i_rx_byte),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_tx_ready        (i_tx_ready),
        .o_tx_valid        (o_tx_valid),
        .o_tx_byte         (o_tx_byte),
        .o_last_byte       (o_last_byte),
        .o_persist_request (o_persist_request),
        .o_persist_slot    (o_persist_slot)
    );

endmodule

`default_nettype wire

[sv/uraf_chk.sv]
// ----------------------------------------------------------------------------
// uraf_chk
// Port-level checks of the frame slave, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module uraf_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_rx_ready,
    input wire       o_tx_valid,
    input wire       i_tx_ready,
    input wire [7:0] o_tx_byte,
    input wire       o_last_byte,
    input wire       o_persist_request,
    input wire [1:0] o_persist_slot
);

    // an answer in progress blocks new request bytes
    a_rx_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && !o_last_byte |-> !o_rx_ready)
        else $error("rx ready while a response is in progress");

    a_persist_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && o_persist_request |-> o_last_byte)
        else $error("persist request away from last byte");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && !o_persist_request |-> (o_persist_slot == 2'd0))
        else $error("persist slot set without request");

    a_tx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_valid && !i_tx_ready |=> o_tx_valid && $stable(o_tx_byte))
        else $error("tx item dropped or changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_tx_valid)
        else $error("tx valid right after reset");

endmodule

bind uart_register_access_frame_slave_core uraf_chk u_chk (.*);

`default_nettype wire
